// ===== sv/smd_pkg.sv =====
// shared constants for the descending merge unit
`timescale 1ns / 1ps

package smd_pkg;

    localparam int LIST_DEPTH_DEFAULT = 32;

    localparam int VALUE_W  = 32;
    localparam int REMAIN_W = 7;

    // command codes carried in s_axis_tuser
    localparam logic [1:0] FUNC_APPEND_A = 2'd0;
    localparam logic [1:0] FUNC_APPEND_B = 2'd1;
    localparam logic [1:0] FUNC_MERGE    = 2'd2;
    localparam logic [1:0] FUNC_TAKE     = 2'd3;

    // status codes carried in m_axis_tuser
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_LIST_FULL  = 2'd1;
    localparam logic [1:0] STATUS_TAKE_EMPTY = 2'd2;

endpackage

// ===== sv/smd_ram.sv =====
// simple dual-port synchronous ram, one write and one registered read port
`timescale 1ns / 1ps

module smd_ram #(
    parameter int DEPTH = smd_pkg::LIST_DEPTH_DEFAULT,
    parameter int WIDTH = smd_pkg::VALUE_W,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/sorted_merge_descending_unit.sv =====
// Descending merge of two ascending lists loaded beat by beat; result stack popped by take
// commands. The unit accepts an append every cycle as long as m_axis_tready does not hold
// the output. A take does one read of the result-stack ram. A merge walks both list rams one
// element per cycle and holds s_axis_tready low until it ends; its single result beat
// appears at the end. Every input beat gives exactly one result beat, through a pending
// stage and the output register, so a new command is taken while an earlier result waits
// on m_axis_tready.
`timescale 1ns / 1ps

module sorted_merge_descending_unit #(
    parameter int LIST_DEPTH = smd_pkg::LIST_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] result_value, [38:32] remaining, [39] zero
    output logic [2:0]  m_axis_tuser    // [0] from_list_b, [2:1] status
);

    localparam int SD   = 2 * LIST_DEPTH;
    localparam int AW   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int SAW  = $clog2(SD);
    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int SCW  = $clog2(SD + 1);
    localparam int VW   = smd_pkg::VALUE_W;
    localparam int RW   = smd_pkg::REMAIN_W;

    localparam logic [CW-1:0]  LD_C = CW'(LIST_DEPTH);
    localparam logic [SCW-1:0] SD_C = SCW'(SD);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_TAKE  = 2'd1;
    localparam logic [1:0] ST_MERGE = 2'd2;

    logic [1:0]     state_reg, state_next;
    logic [CW-1:0]  cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic [CW-1:0]  na_reg, na_next, nb_reg, nb_next;
    logic [CW-1:0]  ia_reg, ia_next, ib_reg, ib_next;
    logic [SCW-1:0] rcnt_reg, rcnt_next;

    logic           pend_valid_reg, pend_valid_next;
    logic [VW-1:0]  pend_value_reg, pend_value_next;
    logic           pend_fromb_reg, pend_fromb_next;
    logic [1:0]     pend_status_reg, pend_status_next;
    logic [RW-1:0]  pend_rem_reg, pend_rem_next;

    logic           out_valid_reg;
    logic [39:0]    out_data_reg;
    logic [2:0]     out_user_reg;

    logic           s_accept, out_free;
    logic [1:0]     func;
    logic [VW-1:0]  a_rdata, b_rdata;
    logic [VW:0]    stk_rdata, stk_wdata;
    logic           a_we, b_we, stk_we;
    logic [AW-1:0]  a_raddr, b_raddr;
    logic [SAW-1:0] stk_raddr;
    logic [CW-1:0]  a_rd_idx, b_rd_idx;
    logic           a_has, b_has, push, take_a;
    logic [SCW-1:0] rcnt_dec;
    logic [SCW+RW-1:0] rem_wide;
    logic [RW-1:0]  rcnt_rem;

    assign func     = s_axis_tuser;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && (!pend_valid_reg || out_free);
    assign s_accept = s_axis_tvalid && s_axis_tready;

    // merge step: heads come from the list rams, read in the previous cycle
    assign a_has  = ia_reg < na_reg;
    assign b_has  = ib_reg < nb_reg;
    assign push   = (state_reg == ST_MERGE) && (a_has || b_has);
    assign take_a = a_has && (!b_has || ($signed(a_rdata) < $signed(b_rdata)));

    assign rcnt_dec = rcnt_reg - SCW'(1);
    assign rem_wide = {{RW{1'b0}}, rcnt_next};
    assign rcnt_rem = rem_wide[RW-1:0];

    always_comb begin
        state_next       = state_reg;
        cnt_a_next       = cnt_a_reg;
        cnt_b_next       = cnt_b_reg;
        na_next          = na_reg;
        nb_next          = nb_reg;
        ia_next          = ia_reg;
        ib_next          = ib_reg;
        rcnt_next        = rcnt_reg;
        pend_valid_next  = pend_valid_reg && !out_free;
        pend_value_next  = pend_value_reg;
        pend_fromb_next  = pend_fromb_reg;
        pend_status_next = pend_status_reg;
        pend_rem_next    = pend_rem_reg;
        a_we             = 1'b0;
        b_we             = 1'b0;
        stk_we           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    pend_value_next  = '0;
                    pend_fromb_next  = 1'b0;
                    pend_status_next = smd_pkg::STATUS_OK;
                    unique case (func)
                        smd_pkg::FUNC_APPEND_A: begin
                            pend_valid_next = 1'b1;
                            if (cnt_a_reg < LD_C) begin
                                a_we       = 1'b1;
                                cnt_a_next = cnt_a_reg + CW'(1);
                            end else begin
                                pend_status_next = smd_pkg::STATUS_LIST_FULL;
                            end
                        end
                        smd_pkg::FUNC_APPEND_B: begin
                            pend_valid_next = 1'b1;
                            if (cnt_b_reg < LD_C) begin
                                b_we       = 1'b1;
                                cnt_b_next = cnt_b_reg + CW'(1);
                            end else begin
                                pend_status_next = smd_pkg::STATUS_LIST_FULL;
                            end
                        end
                        smd_pkg::FUNC_MERGE: begin
                            na_next    = cnt_a_reg;
                            nb_next    = cnt_b_reg;
                            ia_next    = '0;
                            ib_next    = '0;
                            cnt_a_next = '0;
                            cnt_b_next = '0;
                            rcnt_next  = '0;
                            state_next = ST_MERGE;
                        end
                        smd_pkg::FUNC_TAKE: begin
                            if (rcnt_reg != '0) begin
                                rcnt_next  = rcnt_dec;
                                state_next = ST_TAKE;
                            end else begin
                                pend_valid_next  = 1'b1;
                                pend_status_next = smd_pkg::STATUS_TAKE_EMPTY;
                            end
                        end
                        default: ;
                    endcase
                    pend_rem_next = rcnt_rem;
                end
            end
            ST_TAKE: begin
                pend_valid_next  = 1'b1;
                pend_value_next  = stk_rdata[VW-1:0];
                pend_fromb_next  = stk_rdata[VW];
                pend_status_next = smd_pkg::STATUS_OK;
                pend_rem_next    = rcnt_rem;
                state_next       = ST_IDLE;
            end
            ST_MERGE: begin
                if (push) begin
                    stk_we    = 1'b1;
                    rcnt_next = rcnt_reg + SCW'(1);
                    if (take_a) begin
                        ia_next = ia_reg + CW'(1);
                    end else begin
                        ib_next = ib_reg + CW'(1);
                    end
                end else begin
                    pend_valid_next  = 1'b1;
                    pend_value_next  = '0;
                    pend_fromb_next  = 1'b0;
                    pend_status_next = smd_pkg::STATUS_OK;
                    pend_rem_next    = rcnt_rem;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // read one index ahead so the heads are ready next cycle
    assign a_rd_idx  = (state_reg == ST_MERGE) ? ia_next : '0;
    assign b_rd_idx  = (state_reg == ST_MERGE) ? ib_next : '0;
    assign a_raddr   = (a_rd_idx < LD_C) ? a_rd_idx[AW-1:0] : '0;
    assign b_raddr   = (b_rd_idx < LD_C) ? b_rd_idx[AW-1:0] : '0;
    assign stk_raddr = (rcnt_reg != '0) ? rcnt_dec[SAW-1:0] : '0;
    assign stk_wdata = take_a ? {1'b0, a_rdata} : {1'b1, b_rdata};

    smd_ram #(.DEPTH(LIST_DEPTH), .WIDTH(VW)) u_list_a (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (cnt_a_reg[AW-1:0]),
        .wdata (s_axis_tdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    smd_ram #(.DEPTH(LIST_DEPTH), .WIDTH(VW)) u_list_b (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (cnt_b_reg[AW-1:0]),
        .wdata (s_axis_tdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    smd_ram #(.DEPTH(SD), .WIDTH(VW + 1)) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (rcnt_reg[SAW-1:0]),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            rcnt_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            rcnt_reg       <= rcnt_next;
            pend_valid_reg <= pend_valid_next;
            if (out_free) begin
                out_valid_reg <= pend_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        na_reg          <= na_next;
        nb_reg          <= nb_next;
        ia_reg          <= ia_next;
        ib_reg          <= ib_next;
        pend_value_reg  <= pend_value_next;
        pend_fromb_reg  <= pend_fromb_next;
        pend_status_reg <= pend_status_next;
        pend_rem_reg    <= pend_rem_next;
        if (out_free) begin
            out_data_reg <= {1'b0, pend_rem_reg, pend_value_reg};
            out_user_reg <= {pend_status_reg, pend_fromb_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // merge never starts over an unsent result
    a_merge_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MERGE) |-> !pend_valid_reg)
        else $error("pending result during merge");

    a_merge_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MERGE) |-> (ia_reg <= na_reg) && (ib_reg <= nb_reg))
        else $error("merge index past list fill");

    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (rcnt_reg <= SD_C) && (cnt_a_reg <= LD_C) && (cnt_b_reg <= LD_C))
        else $error("fill count beyond depth");

    a_take_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAKE) |=> (state_reg == ST_IDLE) && pend_valid_reg)
        else $error("take did not yield a result");

endmodule
